### rtl/core/bmf_pkg.sv
package bmf_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;
	localparam int MAX_RADIUS  = 7;
	localparam int STORE_DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH + 2 * MAX_RADIUS + 1;

	localparam int COORD_W = 10;
	localparam int DIM_W   = 11;
	localparam int LIN_W   = 21;
	localparam int ADDR_W  = $clog2(STORE_DEPTH);
	localparam int RAD_W   = 3;
	localparam int SPAN_W  = 4;
	localparam int CNT_W   = 8;
	localparam int SUM_W   = 16;
	localparam int DVD_W   = SUM_W + 8;
	localparam int STEP_W  = $clog2(DVD_W);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	localparam logic [15:0] LOW_RESULT = 16'd26;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR_LEVEL  = 3'd3;

	typedef struct packed {
		logic take;
		logic bound;
		logic mul1;
		logic mul2;
		logic addr;
		logic scan;
		logic floor_chk;
		logic div;
		logic emit_adv;
	} bmf_cmd_t;

	typedef struct packed {
		logic ready;
		logic scan_last;
		logic div_last;
	} bmf_stat_t;

endpackage

### rtl/core/bmf_if.sv
interface bmf_in_if;
	import bmf_pkg::*;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] pixel;
	modport source (output valid, output action, output pixel, input ready);
	modport sink (input valid, input action, input pixel, output ready);
endinterface

interface bmf_out_if;
	import bmf_pkg::*;
	logic               valid;
	logic               ready;
	logic [15:0]        mean_value;
	logic [COORD_W-1:0] out_col;
	logic [COORD_W-1:0] out_row;
	logic               frame_last;
	modport source (output valid, output mean_value, output out_col, output out_row,
		output frame_last, input ready);
	modport sink (input valid, input mean_value, input out_col, input out_row,
		input frame_last, output ready);
endinterface

### rtl/core/bmf_ctrl.sv
module bmf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  bmf_pkg::bmf_stat_t stat,
	output bmf_pkg::bmf_cmd_t  cmd
);
	import bmf_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_BOUND = 4'd1;
	localparam logic [3:0] S_MUL1  = 4'd2;
	localparam logic [3:0] S_MUL2  = 4'd3;
	localparam logic [3:0] S_CHECK = 4'd4;
	localparam logic [3:0] S_ADDR  = 4'd5;
	localparam logic [3:0] S_SCAN  = 4'd6;
	localparam logic [3:0] S_TAIL  = 4'd7;
	localparam logic [3:0] S_FLOOR = 4'd8;
	localparam logic [3:0] S_DIV   = 4'd9;
	localparam logic [3:0] S_OUT   = 4'd10;

	logic [3:0] state_q, state_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d = S_BOUND;
				end
			end
			S_BOUND: begin
				cmd.bound = 1'b1;
				state_d = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: state_d = stat.ready ? S_ADDR : S_IDLE;
			S_ADDR: begin
				cmd.addr = 1'b1;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_last) state_d = S_TAIL;
			end
			S_TAIL: state_d = S_FLOOR;
			S_FLOOR: begin
				cmd.floor_chk = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div = 1'b1;
				if (stat.div_last) state_d = S_OUT;
			end
			S_OUT: begin
				if (out_ready) begin
					cmd.emit_adv = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

### rtl/core/bmf_datapath.sv
module bmf_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bmf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bmf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                         action,
	input  logic [7:0]                   pixel,
	input  bmf_pkg::bmf_cmd_t            cmd,
	output bmf_pkg::bmf_stat_t           stat,
	output logic [15:0]                  mean_value,
	output logic [bmf_pkg::COORD_W-1:0]  out_col,
	output logic [bmf_pkg::COORD_W-1:0]  out_row,
	output logic                         frame_last
);
	import bmf_pkg::*;

	logic [DIM_W-1:0] frame_width_q, frame_height_q;
	logic [RAD_W-1:0] radius_q;
	logic [7:0]       floor_level_q;

	logic [COORD_W-1:0] in_col_q, in_row_q, emit_col_q, emit_row_q;
	logic [LIN_W-1:0]   in_lin_q;
	logic [ADDR_W-1:0]  wr_ptr_q;
	logic               frame_done_q;

	logic [7:0] mem [STORE_DEPTH];

	logic [COORD_W-1:0] r0_q, r1_q, c0_q, c1_q, scan_c_q, scan_r_q;
	logic [LIN_W-1:0]   need_q, idx0_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [SUM_W-1:0]   sum_q;
	logic [7:0]         rd_s1;
	logic               rd_v_s1;
	logic               low_q;
	logic [DVD_W-1:0]   dvd_q;
	logic [7:0]         rem_q;
	logic [STEP_W-1:0]  step_q;

	logic [DIM_W-1:0]   w_eff, h_eff;
	logic [RAD_W-1:0]   rad;
	logic [DIM_W-1:0]   r_hi, c_hi;
	logic [COORD_W-1:0] r1_d, c1_d, r0_d, c0_d;
	logic [SPAN_W-1:0]  span_r, span_c;
	logic [LIN_W-1:0]   d0;
	logic [ADDR_W:0]    start_addr, next_addr, step_amt;
	logic [8:0]         trial;
	logic               last_pix, restart;

	assign w_eff = (frame_width_q == '0) ? DIM_W'(1) :
		(frame_width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : frame_width_q;
	assign h_eff = (frame_height_q == '0) ? DIM_W'(1) :
		(frame_height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : frame_height_q;
	assign rad = (radius_q > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_q;

	// clipped window bounds around the next position to emit
	assign r_hi = {1'b0, emit_row_q} + DIM_W'(rad);
	assign c_hi = {1'b0, emit_col_q} + DIM_W'(rad);
	assign r1_d = COORD_W'((r_hi > h_eff - 1'b1) ? h_eff - 1'b1 : r_hi);
	assign c1_d = COORD_W'((c_hi > w_eff - 1'b1) ? w_eff - 1'b1 : c_hi);
	assign r0_d = (emit_row_q > COORD_W'(rad)) ? emit_row_q - COORD_W'(rad) : '0;
	assign c0_d = (emit_col_q > COORD_W'(rad)) ? emit_col_q - COORD_W'(rad) : '0;
	assign span_r = SPAN_W'(r1_q - r0_q);
	assign span_c = SPAN_W'(c1_q - c0_q);

	// distance back from the write head, at most one store depth
	assign d0 = in_lin_q - idx0_q;
	assign start_addr = ({1'b0, wr_ptr_q} >= (ADDR_W+1)'(d0)) ?
		{1'b0, wr_ptr_q} - (ADDR_W+1)'(d0) :
		{1'b0, wr_ptr_q} + (ADDR_W+1)'(STORE_DEPTH) - (ADDR_W+1)'(d0);

	assign step_amt = (scan_c_q == c1_q) ?
		(ADDR_W+1)'(w_eff - DIM_W'(span_c)) : (ADDR_W+1)'(1);
	always_comb begin
		next_addr = {1'b0, addr_q} + step_amt;
		if (next_addr >= (ADDR_W+1)'(STORE_DEPTH))
			next_addr = next_addr - (ADDR_W+1)'(STORE_DEPTH);
	end

	assign trial = {rem_q, dvd_q[DVD_W-1]};

	assign last_pix = ({1'b0, emit_col_q} == w_eff - 1'b1) &&
		({1'b0, emit_row_q} == h_eff - 1'b1);
	assign restart = (cfg_we && cfg_index <= REG_FLOOR_LEVEL) || (cmd.emit_adv && last_pix);

	assign stat.ready     = frame_done_q || (need_q < in_lin_q);
	assign stat.scan_last = (scan_c_q == c1_q) && (scan_r_q == r1_q);
	assign stat.div_last  = (step_q == STEP_W'(DVD_W - 1));

	assign mean_value = low_q ? LOW_RESULT : dvd_q[15:0];
	assign out_col    = emit_col_q;
	assign out_row    = emit_row_q;
	assign frame_last = last_pix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= DIM_W'(1024);
			frame_height_q <= DIM_W'(1024);
			radius_q       <= RAD_W'(1);
			floor_level_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				REG_RADIUS:       radius_q       <= cfg_data[RAD_W-1:0];
				REG_FLOOR_LEVEL:  floor_level_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q     <= '0;
			in_row_q     <= '0;
			in_lin_q     <= '0;
			wr_ptr_q     <= '0;
			frame_done_q <= 1'b0;
			emit_col_q   <= '0;
			emit_row_q   <= '0;
			rd_v_s1      <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.scan;
			if (restart) begin
				in_col_q     <= '0;
				in_row_q     <= '0;
				in_lin_q     <= '0;
				wr_ptr_q     <= '0;
				frame_done_q <= 1'b0;
				emit_col_q   <= '0;
				emit_row_q   <= '0;
			end else begin
				if (cmd.take && !action && !frame_done_q) begin
					in_lin_q <= in_lin_q + 1'b1;
					wr_ptr_q <= (wr_ptr_q == ADDR_W'(STORE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
					if ({1'b0, in_col_q} + 1'b1 >= w_eff) begin
						in_col_q <= '0;
						if ({1'b0, in_row_q} + 1'b1 >= h_eff) begin
							in_row_q     <= '0;
							frame_done_q <= 1'b1;
						end else begin
							in_row_q <= in_row_q + 1'b1;
						end
					end else begin
						in_col_q <= in_col_q + 1'b1;
					end
				end
				if (cmd.emit_adv) begin
					if ({1'b0, emit_col_q} + 1'b1 >= w_eff) begin
						emit_col_q <= '0;
						emit_row_q <= emit_row_q + 1'b1;
					end else begin
						emit_col_q <= emit_col_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && !action && !frame_done_q) mem[wr_ptr_q] <= pixel;
		if (cmd.scan) rd_s1 <= mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.bound) begin
			r0_q <= r0_d;
			r1_q <= r1_d;
			c0_q <= c0_d;
			c1_q <= c1_d;
		end
		if (cmd.mul1)
			need_q <= LIN_W'(LIN_W'(r1_q) * LIN_W'(w_eff)) + LIN_W'(c1_q);
		if (cmd.mul2) begin
			idx0_q <= LIN_W'(LIN_W'(r0_q) * LIN_W'(w_eff)) + LIN_W'(c0_q);
			cnt_q  <= CNT_W'((CNT_W'(span_r) + 1'b1) * (CNT_W'(span_c) + 1'b1));
		end
		if (cmd.addr) begin
			addr_q   <= start_addr[ADDR_W-1:0];
			scan_c_q <= c0_q;
			scan_r_q <= r0_q;
			sum_q    <= '0;
		end else begin
			if (cmd.scan) begin
				addr_q <= next_addr[ADDR_W-1:0];
				if (scan_c_q == c1_q) begin
					scan_c_q <= c0_q;
					scan_r_q <= scan_r_q + 1'b1;
				end else begin
					scan_c_q <= scan_c_q + 1'b1;
				end
			end
			if (rd_v_s1) sum_q <= sum_q + SUM_W'(rd_s1);
		end
		if (cmd.floor_chk) begin
			low_q  <= sum_q < SUM_W'(SUM_W'(floor_level_q) * SUM_W'(cnt_q));
			dvd_q  <= {sum_q, 8'd0} + DVD_W'(cnt_q >> 1);
			rem_q  <= '0;
			step_q <= '0;
		end
		if (cmd.div) begin
			// restoring division, one quotient bit a cycle
			step_q <= step_q + 1'b1;
			if (trial >= {1'b0, cnt_q}) begin
				rem_q <= 8'(trial - {1'b0, cnt_q});
				dvd_q <= {dvd_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[7:0];
				dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			end
		end
	end

endmodule

### rtl/core/box_mean_filter_with_floor_core.sv
// Flow: a beat passes the bound, multiply and check states; when its window is whole,
// the line store is read once per window pixel, then a 24-step serial divider runs.
// One beat at a time; a beat that completes no window goes back to idle after the check.
// Reset: arst_n async, active low; registers to defaults, frame counters to zero.
// The line store holds no reset; every read hits a pixel written this frame.
module box_mean_filter_with_floor_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bmf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bmf_pkg::CFG_DATA_W-1:0] cfg_data,
	bmf_in_if.sink                       in_ch,
	bmf_out_if.source                    out_ch
);
	import bmf_pkg::*;

	bmf_cmd_t  cmd;
	bmf_stat_t stat;

	bmf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bmf_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.action     (in_ch.action),
		.pixel      (in_ch.pixel),
		.cmd        (cmd),
		.stat       (stat),
		.mean_value (out_ch.mean_value),
		.out_col    (out_ch.out_col),
		.out_row    (out_ch.out_row),
		.frame_last (out_ch.frame_last)
	);

endmodule

### rtl/core/bmf_checker.sv
module bmf_sva (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] mean_value
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mean_value))
		else $error("result beat dropped or changed while stalled");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after a beat");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input open while a result is pending");

	a_mean_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> mean_value <= 16'hFF00)
		else $error("mean out of range");

	a_cfg_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !out_valid)
		else $error("result right after a register write");

endmodule

bind box_mean_filter_with_floor_core bmf_sva u_bmf_sva (
	.clk        (clk),
	.arst_n     (arst_n),
	.cfg_we     (cfg_we),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.mean_value (out_ch.mean_value)
);
